// File: sv/ibmw_pkg.sv
// Package: payload structs, codes and constants for the indirect block map walker.
package ibmw_pkg;

   localparam int unsigned DIRECT_POINTERS = 12;
   localparam int unsigned SLOT_COUNT      = 15;

   localparam logic [3:0] SLOT_SINGLE = 4'd12;
   localparam logic [3:0] SLOT_DOUBLE = 4'd13;
   localparam logic [3:0] SLOT_TRIPLE = 4'd14;

   localparam logic [1:0] MODE_LOOKUP   = 2'd0;
   localparam logic [1:0] MODE_RESPONSE = 2'd1;
   localparam logic [1:0] MODE_LOAD     = 2'd2;

   localparam logic KIND_FINAL = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic REG_SIZE_CODE    = 1'b0;
   localparam logic REG_TOTAL_BLOCKS = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] logical_block;
      logic [3:0]  pointer_slot;
      logic [31:0] pointer_value;
      logic [31:0] read_word;
      logic        read_failed;
   } req_data_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] block_address;
      logic [9:0]  word_index;
      logic        error;
   } rsp_data_type;

endpackage

// File: sv/indirect_block_map_walker_core.sv
// Top level: inode-style logical to physical block mapping over the inode pointer table.
//
// Takes one transaction per clock while the result queue has room: a lookup, a pointer
// word response or a pointer load is resolved in the cycle it is accepted, from the
// pointer table, the walk registers and the two configuration registers. A lookup or a
// response to a pending walk pushes its result (a final mapping or a read request for
// one pointer word) into a two-entry result queue. req_ready depends only on the queue
// fill, so a new transaction is taken while a result waits, and rsp_valid rises in the
// cycle after acceptance. The three indirect ranges are checked with parallel compares
// against bounds derived from the size code. After reset the pointer table is all zero
// and no walk is pending; there is no clearing pass.
module indirect_block_map_walker_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ibmw_pkg::req_data_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ibmw_pkg::rsp_data_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import ibmw_pkg::*;

   logic [1:0]   size_code_ff;
   logic [31:0]  total_blocks_ff;
   logic [31:0]  pointer_table_ff [SLOT_COUNT];
   logic         walk_busy_ff, walk_busy_in;
   logic [1:0]   levels_ff, levels_in;
   logic [31:0]  offset_ff, offset_in;

   rsp_data_type rsp_q_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;

   logic         accept, pop, push;
   logic         csr_write;
   logic         table_we;
   rsp_data_type result;
   logic [1:0]   eff_code;
   logic [3:0]   shift1;
   logic [4:0]   shift2, shift3;
   logic [31:0]  bound1, bound2, bound3;
   logic [3:0]   slot_sel;
   logic [31:0]  slot_value;
   logic         do_req;
   logic [31:0]  cand_blk;
   logic [4:0]   idx_shift;
   logic [31:0]  idx_mask;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = rsp_q_ff[rd_ptr_ff];
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (paddr[2])
         REG_SIZE_CODE:    prdata = {30'd0, size_code_ff};
         REG_TOTAL_BLOCKS: prdata = total_blocks_ff;
         default:          prdata = 32'd0;
      endcase
   end

   // Size code three behaves as two.
   assign eff_code = (size_code_ff == 2'd3) ? 2'd2 : size_code_ff;
   assign shift1   = 4'd8 + {2'd0, eff_code};
   assign shift2   = {shift1, 1'b0};
   assign shift3   = shift2 + {1'b0, shift1};
   assign bound1   = 32'(DIRECT_POINTERS) + (32'd1 << shift1);
   assign bound2   = bound1 + (32'd1 << shift2);
   assign bound3   = bound2 + (32'd1 << shift3);
   assign idx_mask = (32'd1 << shift1) - 32'd1;

   // One table read: direct slot or the indirect root for the range hit.
   always_comb begin
      priority if (req_data.logical_block < 32'(DIRECT_POINTERS))
         slot_sel = req_data.logical_block[3:0];
      else if (req_data.logical_block < bound1)
         slot_sel = SLOT_SINGLE;
      else if (req_data.logical_block < bound2)
         slot_sel = SLOT_DOUBLE;
      else
         slot_sel = SLOT_TRIPLE;
   end
   assign slot_value = pointer_table_ff[slot_sel];

   always_comb begin
      walk_busy_in = walk_busy_ff;
      levels_in    = levels_ff;
      offset_in    = offset_ff;
      push         = 1'b0;
      table_we     = 1'b0;
      do_req       = 1'b0;
      cand_blk     = 32'd0;
      idx_shift    = 5'd0;
      result       = '0;
      if (accept) begin
         unique case (req_data.mode)
            MODE_LOAD: begin
               table_we = (req_data.pointer_slot < 4'(SLOT_COUNT));
            end
            MODE_LOOKUP: begin
               walk_busy_in = 1'b0;
               priority if (req_data.logical_block < 32'(DIRECT_POINTERS)) begin
                  push                 = 1'b1;
                  result.kind          = KIND_FINAL;
                  result.block_address = slot_value;
               end else if (req_data.logical_block < bound1) begin
                  levels_in = 2'd1;
                  offset_in = req_data.logical_block - 32'(DIRECT_POINTERS);
                  do_req    = 1'b1;
                  cand_blk  = slot_value;
               end else if (req_data.logical_block < bound2) begin
                  levels_in = 2'd2;
                  offset_in = req_data.logical_block - bound1;
                  do_req    = 1'b1;
                  cand_blk  = slot_value;
               end else if (req_data.logical_block < bound3) begin
                  levels_in = 2'd3;
                  offset_in = req_data.logical_block - bound2;
                  do_req    = 1'b1;
                  cand_blk  = slot_value;
               end else begin
                  // Past the triple range: plain zero result.
                  levels_in   = 2'd0;
                  push        = 1'b1;
                  result.kind = KIND_FINAL;
               end
            end
            MODE_RESPONSE: begin
               if (walk_busy_ff) begin
                  if (req_data.read_failed) begin
                     walk_busy_in = 1'b0;
                     levels_in    = 2'd0;
                     push         = 1'b1;
                     result.kind  = KIND_FINAL;
                     result.error = 1'b1;
                  end else begin
                     levels_in = levels_ff - 2'd1;
                     if (levels_in == 2'd0) begin
                        walk_busy_in         = 1'b0;
                        push                 = 1'b1;
                        result.kind          = KIND_FINAL;
                        result.block_address = req_data.read_word;
                     end else begin
                        do_req   = 1'b1;
                        cand_blk = req_data.read_word;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (do_req) begin
         push = 1'b1;
         unique case (levels_in)
            2'd2:    idx_shift = {1'b0, shift1};
            2'd3:    idx_shift = shift2;
            default: idx_shift = 5'd0;
         endcase
         if (cand_blk == 32'd0) begin
            walk_busy_in = 1'b0;
            result.kind  = KIND_FINAL;
         end else if (cand_blk >= total_blocks_ff) begin
            walk_busy_in = 1'b0;
            result.kind  = KIND_FINAL;
            result.error = 1'b1;
         end else begin
            walk_busy_in         = 1'b1;
            result.kind          = KIND_READ;
            result.block_address = cand_blk;
            result.word_index    = 10'((offset_in >> idx_shift) & idx_mask);
         end
      end
   end

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_code_ff    <= 2'd0;
         total_blocks_ff <= 32'd0;
         walk_busy_ff    <= 1'b0;
         levels_ff       <= 2'd0;
         offset_ff       <= 32'd0;
         wr_ptr_ff       <= 1'b0;
         rd_ptr_ff       <= 1'b0;
         count_ff        <= 2'd0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            pointer_table_ff[i] <= 32'd0;
         end
      end else begin
         if (csr_write) begin
            unique case (paddr[2])
               REG_SIZE_CODE:    size_code_ff    <= pwdata[1:0];
               REG_TOTAL_BLOCKS: total_blocks_ff <= pwdata;
               default: begin
               end
            endcase
         end
         walk_busy_ff <= walk_busy_in;
         levels_ff    <= levels_in;
         offset_ff    <= offset_in;
         if (table_we) begin
            pointer_table_ff[req_data.pointer_slot] <= req_data.pointer_value;
         end
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_q_ff[wr_ptr_ff] <= result;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue overfilled");

   a_walk_levels: assert property (@(posedge clock) disable iff (reset)
      walk_busy_ff |-> levels_ff != 2'd0)
      else $error("pending walk with no level left");

   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_READ) |->
         (!rsp_data.error && rsp_data.block_address != 32'd0))
      else $error("read request carries error or block zero");

   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue fill did not advance on push");

   a_read_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (push && result.kind == KIND_READ) |=> walk_busy_ff)
      else $error("read request issued without a pending walk");

endmodule
